FILE: sv/owk_pkg.sv
`default_nettype none
package owk_pkg;
  localparam int CordicSteps = 14;
  localparam int QueueDepth = 2;
  localparam logic [15:0] LeverReset = 16'd256;
  localparam logic signed [24:0] CordicX0 = 25'sd5094007;
  localparam logic signed [15:0] WHalf = 16'sd16384;
  localparam logic signed [15:0] WSin60 = 16'sd28378;
  localparam logic signed [23:0] SpeedMax = 24'sd8388607;
  localparam logic signed [23:0] SpeedMin = -24'sd8388608;
  localparam logic [10:0] PwmLow = 11'd100;
  localparam logic [10:0] PwmHigh = 11'd1900;
  localparam logic signed [24:0] PwmCenter = 25'sd1000;
  localparam logic [0:0] RegLever = 1'b0;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_ITER,
    FS_FULL
  } front_state_t;

  typedef struct packed {
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] ang_rate;
    logic [7:0] cmd_code;
  } work_t;

  function automatic logic [13:0] atan_val(input logic [3:0] i);
    logic [13:0] r;
    begin
      unique case (i)
        4'd0: r = 14'd8192;
        4'd1: r = 14'd4836;
        4'd2: r = 14'd2555;
        4'd3: r = 14'd1297;
        4'd4: r = 14'd651;
        4'd5: r = 14'd326;
        4'd6: r = 14'd163;
        4'd7: r = 14'd81;
        4'd8: r = 14'd41;
        4'd9: r = 14'd20;
        4'd10: r = 14'd10;
        4'd11: r = 14'd5;
        4'd12: r = 14'd3;
        4'd13: r = 14'd1;
        default: r = 14'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [15:0] clamp_q15(input logic signed [24:0] v);
    logic signed [24:0] t;
    logic signed [16:0] u;
    begin
      t = (v + 25'sd128) >>> 8;
      u = t[16:0];
      if (t > 25'sd32767) return 16'sd32767;
      else if (t < -25'sd32767) return -16'sd32767;
      else return u[15:0];
    end
  endfunction
endpackage
`default_nettype wire

FILE: sv/owk_front.sv
`default_nettype none
module owk_front
  import owk_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] vel_x,
  input  wire logic signed [15:0] vel_y,
  input  wire logic signed [15:0] ang_rate,
  input  wire logic [15:0]        heading,
  input  wire logic [7:0]         cmd_code,
  output logic                    item_valid,
  input  wire logic               item_stall,
  output work_t                   item
);
  front_state_t state, state_next;
  logic [3:0] step;
  logic signed [24:0] cx, cy;
  logic signed [14:0] cz;
  logic signed [24:0] cx_next, cy_next;
  logic signed [14:0] cz_next;
  logic [1:0] quad;
  work_t hold;
  logic signed [15:0] c, s;

  assign in_stall = (state != FS_IDLE);
  assign item_valid = (state == FS_FULL);
  assign item = hold;
  assign c = clamp_q15(cx_next);
  assign s = clamp_q15(cy_next);

  always_comb begin
    if (!cz[14]) begin
      cx_next = cx - (cy >>> step);
      cy_next = cy + (cx >>> step);
      cz_next = cz - $signed({1'b0, atan_val(step)});
    end else begin
      cx_next = cx + (cy >>> step);
      cy_next = cy - (cx >>> step);
      cz_next = cz + $signed({1'b0, atan_val(step)});
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FS_IDLE: if (in_valid) state_next = FS_ITER;
      FS_ITER: if (step == 4'(CordicSteps - 1)) state_next = FS_FULL;
      FS_FULL: if (!item_stall) state_next = FS_IDLE;
      default: state_next = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= FS_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == FS_IDLE && in_valid) begin
      cx <= CordicX0;
      cy <= '0;
      cz <= {1'b0, heading[13:0]};
      quad <= heading[15:14];
      step <= '0;
      hold.vel_x <= vel_x;
      hold.vel_y <= vel_y;
      hold.ang_rate <= ang_rate;
      hold.cmd_code <= cmd_code;
    end else if (state == FS_ITER) begin
      cx <= cx_next;
      cy <= cy_next;
      cz <= cz_next;
      step <= step + 4'd1;
    end
    if (state == FS_ITER && state_next == FS_FULL) begin
      unique case (quad)
        2'd0: begin hold.cos_v <= c; hold.sin_v <= s; end
        2'd1: begin hold.cos_v <= -s; hold.sin_v <= c; end
        2'd2: begin hold.cos_v <= -c; hold.sin_v <= -s; end
        default: begin hold.cos_v <= s; hold.sin_v <= -c; end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/owk_queue.sv
`default_nettype none
module owk_queue
  import owk_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic      wr_stall,
  input  work_t     wr_data,
  output logic      rd_valid,
  input  wire logic rd_stall,
  output work_t     rd_data
);
  work_t slots [QueueDepth];
  logic [$clog2(QueueDepth)-1:0] wp, rp;
  logic [$clog2(QueueDepth):0] count;
  logic push, pop;

  assign wr_stall = (count == ($clog2(QueueDepth)+1)'(QueueDepth));
  assign rd_valid = (count != '0);
  assign rd_data = slots[rp];
  assign push = wr_valid && !wr_stall;
  assign pop = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      count <= count + ($clog2(QueueDepth)+1)'(push) - ($clog2(QueueDepth)+1)'(pop);
    end
    if (push) slots[wp] <= wr_data;
  end
endmodule
`default_nettype wire

FILE: sv/owk_back.sv
`default_nettype none
module owk_back
  import owk_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [15:0]        lever,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  work_t                   item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [23:0]      wheel_speed_a,
  output logic signed [23:0]      wheel_speed_b,
  output logic signed [23:0]      wheel_speed_c,
  output logic [10:0]             pwm_a,
  output logic [10:0]             pwm_b,
  output logic [10:0]             pwm_c,
  output logic [7:0]              cmd_out
);
  logic v1, v2, v3, v4;
  logic adv;
  logic signed [20:0] a0;
  logic signed [16:0] a1, qr;
  logic signed [36:0] p_ca0, p_sa1, p_ca1, p_sa0;
  logic signed [33:0] p_lq;
  logic signed [37:0] rx, ry;
  logic signed [33:0] lq, lq3;
  logic [7:0] c1, c2, c3;
  logic signed [63:0] rate, wa, wb, wc;
  logic signed [54:0] ha, hb, hc;

  assign out_valid = v4;
  assign adv = !(v4 && out_stall);
  assign item_stall = !adv;
  assign a0 = -(21'(item.vel_x) * 21'sd10);
  assign a1 = -17'(item.vel_y);
  assign qr = -17'(item.ang_rate);

  function automatic logic signed [23:0] sat(input logic signed [63:0] v);
    logic signed [63:0] r;
    begin
      r = (v + 64'sd536870912) >>> 30;
      if (r > 64'(SpeedMax)) return SpeedMax;
      else if (r < 64'(SpeedMin)) return SpeedMin;
      else return r[23:0];
    end
  endfunction

  function automatic logic [10:0] pwm(input logic signed [23:0] sp);
    logic signed [24:0] p;
    begin
      p = 25'(sp) + PwmCenter;
      if (p >= $signed({14'd0, PwmHigh})) return PwmHigh;
      else if (p <= $signed({14'd0, PwmLow})) return PwmLow;
      else return p[10:0];
    end
  endfunction

  assign rate = 64'(lq3) <<< 22;
  assign wa = 64'(ha) - rate;
  assign wb = 64'(hb) - rate;
  assign wc = 64'(hc) - rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= item_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    if (adv) begin
      p_ca0 <= 37'(item.cos_v) * 37'(a0);
      p_sa1 <= 37'(item.sin_v) * 37'(a1);
      p_ca1 <= 37'(item.cos_v) * 37'(a1);
      p_sa0 <= 37'(item.sin_v) * 37'(a0);
      p_lq <= $signed({18'd0, lever}) * 34'(qr);
      c1 <= item.cmd_code;
      rx <= 38'(p_ca0) + 38'(p_sa1);
      ry <= 38'(p_ca1) - 38'(p_sa0);
      lq <= p_lq;
      c2 <= c1;
      ha <= 55'(rx) * 55'(WHalf) + 55'(ry) * 55'(WSin60);
      hb <= -(55'(rx) <<< 15);
      hc <= 55'(rx) * 55'(WHalf) - 55'(ry) * 55'(WSin60);
      lq3 <= lq;
      c3 <= c2;
      if (v3) begin
        wheel_speed_a <= sat(wa);
        wheel_speed_b <= sat(wb);
        wheel_speed_c <= sat(wc);
        pwm_a <= pwm(sat(wa));
        pwm_b <= pwm(sat(wb));
        pwm_c <= pwm(sat(wc));
        cmd_out <= c3;
      end
    end
  end
endmodule
`default_nettype wire

FILE: sv/omni_wheel_kinematics_pwm.sv
`default_nettype none
// Three-wheel omni inverse kinematics with PWM mapping. The front end computes sine and
// cosine of the heading with a 14-step CORDIC, one step per clock, and accepts no new
// transaction until the current one has been passed on; a two-entry queue feeds a
// four-stage multiply pipeline that turns each into three saturated wheel speeds and PWM
// values.
// Register 0 at address 0 holds the lever arm in unsigned Q8.8 and resets to 1.0.
module omni_wheel_kinematics_pwm
  import owk_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [0:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] vel_x,
  input  wire logic signed [15:0] vel_y,
  input  wire logic signed [15:0] ang_rate,
  input  wire logic [15:0]        heading,
  input  wire logic [7:0]         cmd_code,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [23:0]      wheel_speed_a,
  output logic signed [23:0]      wheel_speed_b,
  output logic signed [23:0]      wheel_speed_c,
  output logic [10:0]             pwm_a,
  output logic [10:0]             pwm_b,
  output logic [10:0]             pwm_c,
  output logic [7:0]              cmd_out
);
  logic [15:0] lever;
  logic fq_valid, fq_stall, qb_valid, qb_stall;
  work_t fq_data, qb_data;

  assign pready = 1'b1;
  assign prdata = (paddr == RegLever) ? {16'd0, lever} : '0;

  always_ff @(posedge clk) begin
    if (rst) lever <= LeverReset;
    else if (psel && penable && pwrite && paddr == RegLever) lever <= pwdata[15:0];
  end

  owk_front u_front (
    .clk, .rst, .in_valid, .in_stall, .vel_x, .vel_y, .ang_rate, .heading, .cmd_code,
    .item_valid(fq_valid), .item_stall(fq_stall), .item(fq_data)
  );

  owk_queue u_queue (
    .clk, .rst, .wr_valid(fq_valid), .wr_stall(fq_stall), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_stall(qb_stall), .rd_data(qb_data)
  );

  owk_back u_back (
    .clk, .rst, .lever, .item_valid(qb_valid), .item_stall(qb_stall), .item(qb_data),
    .out_valid, .out_stall, .wheel_speed_a, .wheel_speed_b, .wheel_speed_c,
    .pwm_a, .pwm_b, .pwm_c, .cmd_out
  );

`ifndef SYNTHESIS
  a_pwm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pwm_a >= PwmLow && pwm_a <= PwmHigh)) else $error("pwm out of range");
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("front accepted twice");
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(cmd_out)) else $error("result changed while held");
`endif
endmodule
`default_nettype wire

FILE: dv/testbench.sv
`default_nettype none
module testbench;
  import owk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [23:0] spd_a, spd_b, spd_c;
    logic [10:0] pa, pb, pc;
    logic [7:0] code;
  } wheel_cmd_t;

  typedef struct {
    logic signed [15:0] vx, vy, w;
    logic [15:0] hdg;
    logic [7:0] code;
    logic known;
    wheel_cmd_t res;
  } row_t;

  localparam int Limit = 2000000;
  localparam int TailCycles = 40;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [0:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [15:0] vel_x, vel_y, ang_rate;
  logic [15:0] heading;
  logic [7:0] cmd_code;
  logic signed [23:0] wheel_speed_a, wheel_speed_b, wheel_speed_c;
  logic [10:0] pwm_a, pwm_b, pwm_c;
  logic [7:0] cmd_out;

  wheel_cmd_t expected_cmds[$];
  logic [15:0] lever;
  int errors = 0;
  int cycles = 0;
  int received = 0;
  int sent = 0;
  bit long_stalls = 0;

  omni_wheel_kinematics_pwm DUT (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic void cordic_sincos(input logic [15:0] ang,
                                        output logic signed [31:0] co,
                                        output logic signed [31:0] si);
    logic signed [31:0] x, y, z, dx, dy, c, s;
    int tab[14];
    tab = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
    x = 5094007;
    y = 0;
    z = {18'd0, ang[13:0]};
    for (int i = 0; i < 14; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= tab[i];
      end else begin
        x += dx; y -= dy; z += tab[i];
      end
    end
    c = (x + 128) >>> 8;
    s = (y + 128) >>> 8;
    if (c > 32767) c = 32767;
    if (c < -32767) c = -32767;
    if (s > 32767) s = 32767;
    if (s < -32767) s = -32767;
    case (ang[15:14])
      2'd0: begin co = c; si = s; end
      2'd1: begin co = -s; si = c; end
      2'd2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
  endfunction

  function automatic logic signed [23:0] round_speed(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< 29)) >>> 30;
    if (r > 64'sd8388607) return SpeedMax;
    if (r < -64'sd8388608) return SpeedMin;
    return r[23:0];
  endfunction

  function automatic logic [10:0] speed_to_pwm(input logic signed [23:0] sp);
    logic signed [31:0] p;
    p = sp + 1000;
    if (p >= 1900) return PwmHigh;
    if (p <= 100) return PwmLow;
    return p[10:0];
  endfunction

  function automatic wheel_cmd_t wheel_commands(input row_t r);
    wheel_cmd_t o;
    logic signed [31:0] co, si;
    logic signed [63:0] a0, a1, q, rx, ry, rate;
    cordic_sincos(r.hdg, co, si);
    a0 = -64'sd10 * r.vx;
    a1 = -64'(r.vy);
    q = -64'(r.w);
    rx = co * a0 + si * a1;
    ry = co * a1 - si * a0;
    rate = $signed({48'd0, lever}) * q * (64'sd1 <<< 22);
    o.spd_a = round_speed(64'sd16384 * rx + 64'sd28378 * ry - rate);
    o.spd_b = round_speed(-64'sd32768 * rx - rate);
    o.spd_c = round_speed(64'sd16384 * rx - 64'sd28378 * ry - rate);
    o.pa = speed_to_pwm(o.spd_a);
    o.pb = speed_to_pwm(o.spd_b);
    o.pc = speed_to_pwm(o.spd_c);
    o.code = r.code;
    return o;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= long_stalls ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0);
      if (out_valid && !out_stall) begin
        received <= received + 1;
        if (expected_cmds.size() == 0) begin
          $error("unexpected transaction, cmd_out %0d", cmd_out);
          errors++;
        end else begin
          wheel_cmd_t e;
          e = expected_cmds.pop_front();
          if (wheel_speed_a !== e.spd_a) begin
            $error("wheel_speed_a exp %0d got %0d", e.spd_a, wheel_speed_a); errors++;
          end
          if (wheel_speed_b !== e.spd_b) begin
            $error("wheel_speed_b exp %0d got %0d", e.spd_b, wheel_speed_b); errors++;
          end
          if (wheel_speed_c !== e.spd_c) begin
            $error("wheel_speed_c exp %0d got %0d", e.spd_c, wheel_speed_c); errors++;
          end
          if (pwm_a !== e.pa) begin
            $error("pwm_a exp %0d got %0d", e.pa, pwm_a); errors++;
          end
          if (pwm_b !== e.pb) begin
            $error("pwm_b exp %0d got %0d", e.pb, pwm_b); errors++;
          end
          if (pwm_c !== e.pc) begin
            $error("pwm_c exp %0d got %0d", e.pc, pwm_c); errors++;
          end
          if (cmd_out !== e.code) begin
            $error("cmd_out exp %0d got %0d", e.code, cmd_out); errors++;
          end
        end
      end
    end
  end

  task automatic write_lever(input logic [15:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= RegLever; pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    lever = v;
  endtask

  task automatic send(input row_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    vel_x <= r.vx; vel_y <= r.vy; ang_rate <= r.w; heading <= r.hdg; cmd_code <= r.code;
    if (r.known) expected_cmds.push_back(r.res);
    else expected_cmds.push_back(wheel_commands(r));
    sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  function automatic row_t mk(input int vx, input int vy, input int w, input int hdg,
                              input int code);
    row_t r;
    r.vx = 16'(vx); r.vy = 16'(vy); r.w = 16'(w); r.hdg = 16'(hdg); r.code = 8'(code);
    r.known = 1'b0;
    return r;
  endfunction

  function automatic row_t random_row();
    row_t r;
    int sel;
    sel = $urandom_range(0, 3);
    r = mk($urandom, $urandom, $urandom, $urandom, $urandom);
    if (sel == 0) begin
      r.vx = 16'(int'($urandom_range(0, 200)) - 100);
      r.vy = 16'(int'($urandom_range(0, 2000)) - 1000);
      r.w = 16'(int'($urandom_range(0, 600)) - 300);
    end else if (sel == 1) begin
      r.hdg = {2'($urandom_range(0, 3)), 14'd0};
    end
    return r;
  endfunction

  initial begin
    row_t table_rows[$];
    row_t r;
    logic [15:0] levers[5];
    levers = '{16'd0, 16'd65535, 16'd1, 16'd128, 16'd40000};
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0;
    vel_x = '0; vel_y = '0; ang_rate = '0; heading = '0; cmd_code = '0;
    lever = LeverReset;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed rows; known results are typed in where obvious.
    r = mk(0, 0, 0, 0, 8'h41); r.known = 1'b1;
    r.res = '{24'sd0, 24'sd0, 24'sd0, 11'd1000, 11'd1000, 11'd1000, 8'h41};
    table_rows.push_back(r);
    r = mk(0, 0, 32767, 0, 8'hFF); r.known = 1'b1;
    r.res = '{24'sd32767, 24'sd32767, 24'sd32767, PwmHigh, PwmHigh, PwmHigh, 8'hFF};
    table_rows.push_back(r);
    r = mk(0, 0, -32768, 16'hFFFF, 8'h00); r.known = 1'b1;
    r.res = '{-24'sd32768, -24'sd32768, -24'sd32768, PwmLow, PwmLow, PwmLow, 8'h00};
    table_rows.push_back(r);
    table_rows.push_back(mk(32767, 32767, 32767, 16'h0000, 1));
    table_rows.push_back(mk(-32768, -32768, -32768, 16'h4000, 2));
    table_rows.push_back(mk(-32768, 32767, 0, 16'h8000, 3));
    table_rows.push_back(mk(32767, -32768, 0, 16'hC000, 4));
    table_rows.push_back(mk(100, 0, 0, 16'h2000, 5));
    table_rows.push_back(mk(0, 100, 0, 16'h3FFF, 6));
    table_rows.push_back(mk(1, 1, 1, 16'h5555, 7));
    table_rows.push_back(mk(-1, -1, -1, 16'hAAAA, 8));
    table_rows.push_back(mk(90, 0, 0, 0, 9));
    table_rows.push_back(mk(-90, 0, 0, 0, 10));
    table_rows.push_back(mk(0, 0, 900, 0, 11));
    foreach (table_rows[i]) send(table_rows[i]);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_lever(levers[ph]);
      send(mk(0, 0, -32768, 0, ph));
      send(mk(0, 0, 32767, 16'h1234, ph));
      long_stalls = (ph == 2);
      for (int n = 0; n < 290; n++) begin
        send(random_row());
        if (n == 150) begin
          in_valid <= 1'b0;
          while (expected_cmds.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    long_stalls = 0;
    write_lever(LeverReset);
    for (int n = 0; n < 20; n++) send(random_row());
    drain();

    $display("Sent %0d transactions over six lever arm settings, including 0 and 65535;",
             sent);
    $display("received %0d, with speed saturation, PWM clamping and all quadrants.", received);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: omni_wheel_kinematics_pwm.f
sv/owk_pkg.sv
sv/owk_front.sv
sv/owk_queue.sv
sv/owk_back.sv
sv/omni_wheel_kinematics_pwm.sv
dv/testbench.sv
